[design/hba_pkg.sv]
`timescale 1ns / 1ps

package hba_pkg;

	// Default geometry of the bin store.
	localparam int NUM_BINS_DEF    = 256;
	localparam int COUNT_WIDTH_DEF = 32;

	// Fixed widths of the channel payload and the class count register.
	localparam int KIND_W    = 2;
	localparam int INDEX_W   = 8;
	localparam int OUT_W     = 32;
	localparam int CLASS_W   = 9;

	localparam logic [CLASS_W-1:0] CLASS_COUNT_RESET = 9'd256;
	localparam logic [OUT_W-1:0]   OUT_MAX           = 32'hFFFF_FFFF;

	// Item kinds. The unused code behaves as a read.
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_ADD   = 2'd0;
	localparam kind_t KIND_CLEAR = 2'd1;
	localparam kind_t KIND_READ  = 2'd2;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_EXEC  = 4'b0010,
		ST_CLEAR = 4'b0100,
		ST_INIT  = 4'b1000
	} state_t;

endpackage

[design/hba_if.sv]
`timescale 1ns / 1ps

// Channel carrying one histogram operation.
interface hba_in_if;
	import hba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [INDEX_W-1:0]   bin_index;

	modport source (output valid, kind, bin_index, input ready);
	modport sink   (input valid, kind, bin_index, output ready);
endinterface

// Channel carrying one result of an operation.
interface hba_out_if;
	import hba_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUT_W-1:0]     bin_count;
	logic [OUT_W-1:0]     peak_count;
	logic                 has_data;
	logic                 in_range;

	modport source (output valid, bin_count, peak_count, has_data, in_range, input ready);
	modport sink   (input valid, bin_count, peak_count, has_data, in_range, output ready);
endinterface

[design/histogram_bin_accumulator_unit.sv]
`timescale 1ns / 1ps
// Flow: an add or read that is taken is held in the operand registers while its bin is read,
// then its result is loaded into the result register once that is free. A clear first
// zeroes the store one bin a cycle and then reports. No item is taken while the one
// before reads its bin and writes it back. The result register frees the input side.
// Reset: asynchronous, active low; afterwards a pass zeroes the store
// and no item is taken until it ends. Class count resets to 256.
module histogram_bin_accumulator_unit #(
	parameter int NUM_BINS    = hba_pkg::NUM_BINS_DEF,
	parameter int COUNT_WIDTH = hba_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hba_pkg::CLASS_W-1:0]   cfg_wdata,
	hba_in_if.sink                        items,
	hba_out_if.source                     results
);
	import hba_pkg::*;

	localparam int AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CMPW = ($clog2(NUM_BINS + 1) > CLASS_W) ? $clog2(NUM_BINS + 1) : CLASS_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

	state_t                 state_q;
	logic [AW-1:0]          sweep_addr_q;
	logic [CLASS_W-1:0]     class_q;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic                   seen_q;

	kind_t                  kind_s1;
	logic [AW-1:0]          addr_s1;
	logic                   ok_s1;

	logic                   out_valid_q;
	logic [OUT_W-1:0]       bin_count_q;
	logic [OUT_W-1:0]       peak_count_q;
	logic                   has_data_q;
	logic                   in_range_q;

	logic                   accept;
	logic                   ok_c;
	logic [AW-1:0]          in_addr;
	logic                   out_free;
	logic                   exec_go;
	logic                   add_go;
	logic                   sweeping;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic [COUNT_WIDTH-1:0] rd_count;
	logic [COUNT_WIDTH-1:0] new_count;
	logic [COUNT_WIDTH-1:0] new_peak;
	logic [COUNT_WIDTH-1:0] cnt_c;
	logic [COUNT_WIDTH-1:0] peak_c;

	// Input transfer and range check against min(class count, NUM_BINS).
	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign in_addr     = AW'(items.bin_index);
	assign ok_c        = (CLASS_W'(items.bin_index) < class_q)
	                     && (CMPW'(items.bin_index) < CMPW'(NUM_BINS));

	assign out_free = !out_valid_q || results.ready;
	assign exec_go  = (state_q == ST_EXEC) && out_free;
	assign add_go   = exec_go && (kind_s1 == KIND_ADD) && ok_s1;
	assign sweeping = (state_q == ST_CLEAR) || (state_q == ST_INIT);

	// Memory write: zero during a sweep, the incremented count on an add.
	assign mem_we    = sweeping || add_go;
	assign mem_waddr = sweeping ? sweep_addr_q : addr_s1;
	assign mem_wdata = sweeping ? '0 : new_count;

	hba_bin_mem #(
		.DEPTH (NUM_BINS),
		.WIDTH (COUNT_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (in_addr),
		.rdata (rd_count)
	);

	hba_bin_update #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_update (
		.old_count (rd_count),
		.peak      (peak_q),
		.new_count (new_count),
		.new_peak  (new_peak)
	);

	// Result values of the item in execution.
	always_comb begin
		cnt_c  = '0;
		peak_c = peak_q;
		if (ok_s1 && (kind_s1 != KIND_CLEAR)) begin
			if (kind_s1 == KIND_ADD) begin
				cnt_c  = new_count;
				peak_c = new_peak;
			end else begin
				cnt_c = rd_count;
			end
		end
	end

	// Class count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_COUNT_RESET;
		end else if (cfg_we) begin
			class_q <= cfg_wdata;
		end
	end

	// Sequencer: idle, execute, clear sweep and the sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_addr_q <= '0;
			peak_q       <= '0;
			seen_q       <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (items.kind == KIND_CLEAR) begin
							peak_q       <= '0;
							seen_q       <= 1'b0;
							sweep_addr_q <= '0;
							state_q      <= ST_CLEAR;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						if (add_go) begin
							peak_q <= new_peak;
							seen_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR, ST_INIT: begin
					if (sweep_addr_q == LAST_ADDR) begin
						sweep_addr_q <= '0;
						state_q      <= (state_q == ST_CLEAR) ? ST_EXEC : ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// Operands of the item taken, held through execution.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= items.kind;
			addr_s1 <= in_addr;
			ok_s1   <= ok_c;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, clipped to the 32-bit output fields.
	always_ff @(posedge clk) begin
		if (exec_go) begin
			bin_count_q  <= (cnt_c > COUNT_WIDTH'(OUT_MAX)) ? OUT_MAX : OUT_W'(cnt_c);
			peak_count_q <= (peak_c > COUNT_WIDTH'(OUT_MAX)) ? OUT_MAX : OUT_W'(peak_c);
			has_data_q   <= seen_q || add_go;
			in_range_q   <= ok_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.bin_count  = bin_count_q;
	assign results.peak_count = peak_count_q;
	assign results.has_data   = has_data_q;
	assign results.in_range   = in_range_q;

	// The memory is never written in the cycle an item is taken.
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && accept))
		else $error("bin memory written while an item is taken");

	// An in-range add sets the has-data flag.
	a_add_sets_seen: assert property (@(posedge clk) disable iff (!arst_n)
		add_go |=> seen_q)
		else $error("has-data flag not set after an add");

	// The peak never falls except through a clear.
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> (peak_q >= $past(peak_q)))
		else $error("peak count fell during execution");

	// A finished result is only loaded when the result register is free.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=> ($stable(bin_count_q) && out_valid_q))
		else $error("pending result overwritten");

endmodule

[design/hba_bin_mem.sv]
`timescale 1ns / 1ps

module hba_bin_mem #(
	parameter int DEPTH = hba_pkg::NUM_BINS_DEF,
	parameter int WIDTH = hba_pkg::COUNT_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import hba_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/hba_bin_update.sv]
`timescale 1ns / 1ps

module hba_bin_update #(
	parameter int COUNT_WIDTH = hba_pkg::COUNT_WIDTH_DEF
) (
	input  logic [COUNT_WIDTH-1:0] old_count,
	input  logic [COUNT_WIDTH-1:0] peak,
	output logic [COUNT_WIDTH-1:0] new_count,
	output logic [COUNT_WIDTH-1:0] new_peak
);
	import hba_pkg::*;

	// Increment with saturation at the all-ones value.
	always_comb begin
		if (&old_count) begin
			new_count = old_count;
		end else begin
			new_count = old_count + COUNT_WIDTH'(1);
		end
	end

	// The peak follows the incremented bin when it overtakes it.
	assign new_peak = (new_count > peak) ? new_count : peak;

endmodule

[tb/sv/histogram_bin_accumulator_unit_tb.sv]
`timescale 1ns / 1ps

module histogram_bin_accumulator_unit_tb;
	import hba_pkg::*;

	localparam real CLK_PERIOD  = 4.0;
	localparam int  BINS        = NUM_BINS_DEF;
	localparam int  CW          = COUNT_WIDTH_DEF;
	localparam int  LONG_HOLD   = 150;
	localparam int  DRAIN_WAIT  = 16;
	localparam int  PHASES      = 3;
	localparam int  CHUNKS      = 5;
	localparam int  CHUNK_ITEMS = 90;
	// Roughly 1400 items, about 50 clears of the whole store and the clearing pass
	// after reset; the limit allows several times the time they take.
	localparam real RUN_LIMIT   = 2_000_000.0;

	// The spare kind code carries no operation and reports like a read.
	localparam kind_t KIND_NOP = 2'd3;

	typedef struct packed {
		logic [OUT_W-1:0] bin_count;
		logic [OUT_W-1:0] peak_count;
		logic             has_data;
		logic             in_range;
	} hist_result_t;

	// One row of the directed sequence: a class count write or an operation.
	typedef struct packed {
		bit                   is_cfg;
		logic [CLASS_W-1:0]   cfg_val;
		kind_t                kind;
		logic [INDEX_W-1:0]   bin_index;
		bit                   typed;
		hist_result_t         want;
	} step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CLASS_W-1:0] cfg_wdata;

	hba_in_if  items_ch ();
	hba_out_if results_ch ();

	histogram_bin_accumulator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items_ch),
		.results   (results_ch)
	);

	// Shadow state of the histogram.
	logic [CW-1:0]      bin_store [BINS];
	logic [CW-1:0]      peak_seen;
	logic               data_seen;
	logic [CLASS_W-1:0] class_count;

	hist_result_t       pending_results [$];
	int                 mismatch_count;
	int                 src_idle_pct;
	int                 snk_idle_pct;
	int                 hold_requests;
	int                 holds_served;
	logic [INDEX_W-1:0] hot_bins [3];

	// Directed sequence: extremes, every kind, class count corner values.
	step_t directed_plan [29] = '{
		'{1'b0, 9'd0,   KIND_READ,  8'd0,   1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
		'{1'b0, 9'd0,   KIND_NOP,   8'd255, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
		'{1'b0, 9'd0,   KIND_ADD,   8'd0,   1'b1, '{32'd1, 32'd1, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_ADD,   8'd0,   1'b1, '{32'd2, 32'd2, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_ADD,   8'd255, 1'b1, '{32'd1, 32'd2, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_READ,  8'd255, 1'b0, '0},
		'{1'b0, 9'd0,   KIND_NOP,   8'd0,   1'b0, '0},
		'{1'b1, 9'd1,   KIND_READ,  8'd0,   1'b0, '0},
		'{1'b0, 9'd0,   KIND_ADD,   8'd1,   1'b1, '{32'd0, 32'd2, 1'b1, 1'b0}},
		'{1'b0, 9'd0,   KIND_ADD,   8'd0,   1'b1, '{32'd3, 32'd3, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_CLEAR, 8'd200, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
		'{1'b0, 9'd0,   KIND_READ,  8'd0,   1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
		'{1'b1, 9'd0,   KIND_READ,  8'd0,   1'b0, '0},
		'{1'b0, 9'd0,   KIND_ADD,   8'd0,   1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
		'{1'b0, 9'd0,   KIND_READ,  8'd0,   1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
		'{1'b0, 9'd0,   KIND_CLEAR, 8'd0,   1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
		'{1'b1, 9'd511, KIND_READ,  8'd0,   1'b0, '0},
		'{1'b0, 9'd0,   KIND_ADD,   8'd255, 1'b1, '{32'd1, 32'd1, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_ADD,   8'hAA,  1'b0, '0},
		'{1'b0, 9'd0,   KIND_ADD,   8'h55,  1'b0, '0},
		'{1'b1, 9'd128, KIND_READ,  8'd0,   1'b0, '0},
		'{1'b0, 9'd0,   KIND_READ,  8'd255, 1'b1, '{32'd0, 32'd1, 1'b1, 1'b0}},
		'{1'b0, 9'd0,   KIND_READ,  8'd127, 1'b0, '0},
		'{1'b0, 9'd0,   KIND_ADD,   8'd128, 1'b1, '{32'd0, 32'd1, 1'b1, 1'b0}},
		'{1'b1, 9'd256, KIND_READ,  8'd0,   1'b0, '0},
		'{1'b0, 9'd0,   KIND_READ,  8'd255, 1'b1, '{32'd1, 32'd1, 1'b1, 1'b1}},
		'{1'b0, 9'd0,   KIND_CLEAR, 8'd255, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
		'{1'b0, 9'd0,   KIND_READ,  8'd255, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1}},
		'{1'b0, 9'd0,   KIND_ADD,   8'd255, 1'b0, '0}
	};

	// Clock generator.
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Applies one operation to the shadow histogram and returns its report.
	function automatic hist_result_t histo_update(input kind_t kind,
			input logic [INDEX_W-1:0] idx);
		hist_result_t r;
		int unsigned  limit;
		bit           hit;
		limit = (class_count < BINS) ? int'(class_count) : BINS;
		hit = (idx < limit);
		r = '0;
		if (kind == KIND_CLEAR) begin
			foreach (bin_store[i])
				bin_store[i] = '0;
			peak_seen = '0;
			data_seen = 1'b0;
		end else if (hit) begin
			if (kind == KIND_ADD) begin
				// Counters stick at all ones.
				if (bin_store[idx] != '1)
					bin_store[idx] = bin_store[idx] + 1'b1;
				if (bin_store[idx] > peak_seen)
					peak_seen = bin_store[idx];
				data_seen = 1'b1;
			end
			r.bin_count = bin_store[idx];
		end
		r.peak_count = peak_seen;
		r.has_data   = data_seen;
		r.in_range   = hit;
		return r;
	endfunction

	// Offers one operation, with random idle cycles first, and records the
	// expected report once the transfer has happened.
	task automatic send_item(input kind_t kind, input logic [INDEX_W-1:0] idx,
			input bit typed, input hist_result_t want);
		hist_result_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			items_ch.valid     <= 1'b0;
			items_ch.kind      <= kind_t'($urandom);
			items_ch.bin_index <= INDEX_W'($urandom);
			@(negedge clk);
		end
		items_ch.valid     <= 1'b1;
		items_ch.kind      <= kind;
		items_ch.bin_index <= idx;
		do
			@(posedge clk);
		while (!items_ch.ready);
		predicted = histo_update(kind, idx);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Writes the class count once every outstanding report has come back.
	task automatic write_class_count(input logic [CLASS_W-1:0] value);
		@(negedge clk);
		items_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		class_count = value;
	endtask

	// Picks a class count for the next stretch, favouring the corner values.
	function automatic logic [CLASS_W-1:0] pick_class_count();
		case ($urandom_range(0, 9))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd511;
			3: return 9'd256;
			4: return 9'd255;
			default: return CLASS_W'($urandom_range(1, 511));
		endcase
	endfunction

	// Chooses a few busy bins inside the current class range, or anywhere when it is zero, one at its top edge.
	task automatic pick_hot_bins();
		int span;
		span = (class_count == 0) ? BINS : ((class_count < BINS) ? class_count : BINS);
		hot_bins[0] = INDEX_W'(span - 1);
		hot_bins[1] = INDEX_W'($urandom_range(0, span - 1));
		hot_bins[2] = INDEX_W'($urandom_range(0, span - 1));
	endtask

	// Random operation: mostly adds to busy bins so that counts and peak climb.
	task automatic send_random_item();
		kind_t              k;
		logic [INDEX_W-1:0] idx;
		int                 r;
		r = $urandom_range(0, 99);
		if (r < 62)
			k = KIND_ADD;
		else if (r < 86)
			k = KIND_READ;
		else if (r < 89)
			k = KIND_CLEAR;
		else
			k = KIND_NOP;
		r = $urandom_range(0, 9);
		if (r < 6)
			idx = hot_bins[$urandom_range(0, 2)];
		else if (r == 6)
			idx = {INDEX_W{1'($urandom_range(0, 1))}};
		else
			idx = INDEX_W'($urandom_range(0, 255));
		send_item(k, idx, 1'b0, '0);
	endtask

	// Result side: random back-pressure, plus one long hold when asked for.
	initial begin
		results_ch.ready = 1'b0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				results_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			results_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// Each report transfer is compared with the oldest expectation.
	always @(posedge clk) begin : check_result
		hist_result_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("report transfer with nothing expected");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (results_ch.bin_count !== want.bin_count) begin
					$error("bin_count: expected %0d, got %0d", want.bin_count,
						results_ch.bin_count);
					mismatch_count++;
				end
				if (results_ch.peak_count !== want.peak_count) begin
					$error("peak_count: expected %0d, got %0d", want.peak_count,
						results_ch.peak_count);
					mismatch_count++;
				end
				if (results_ch.has_data !== want.has_data) begin
					$error("has_data: expected %0d, got %0d", want.has_data,
						results_ch.has_data);
					mismatch_count++;
				end
				if (results_ch.in_range !== want.in_range) begin
					$error("in_range: expected %0d, got %0d", want.in_range,
						results_ch.in_range);
					mismatch_count++;
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		items_ch.valid     = 1'b0;
		items_ch.kind      = KIND_ADD;
		items_ch.bin_index = '0;
		mismatch_count     = 0;
		hold_requests      = 0;
		src_idle_pct       = 37;
		snk_idle_pct       = 49;
		foreach (bin_store[i])
			bin_store[i] = '0;
		peak_seen   = '0;
		data_seen   = 1'b0;
		class_count = CLASS_COUNT_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sequence.
		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg)
				write_class_count(directed_plan[i].cfg_val);
			else
				send_item(directed_plan[i].kind, directed_plan[i].bin_index,
					directed_plan[i].typed, directed_plan[i].want);
		end

		// Random part: receiver-heavy idling, sender-heavy idling, then none.
		for (int ph = 0; ph < PHASES; ph++) begin
			src_idle_pct = (ph == 0) ? 37 : ((ph == 1) ? 49 : 0);
			snk_idle_pct = (ph == 0) ? 49 : ((ph == 1) ? 37 : 0);
			for (int ch = 0; ch < CHUNKS; ch++) begin
				write_class_count(pick_class_count());
				pick_hot_bins();
				// Stall the report side while items keep coming, so the block backs up.
				if (ph == PHASES - 1 && ch == 0)
					hold_requests++;
				for (int n = 0; n < CHUNK_ITEMS; n++)
					send_random_item();
			end
		end

		@(negedge clk);
		items_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog.
	initial begin
		#(RUN_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
design/hba_pkg.sv
design/hba_if.sv
design/hba_bin_mem.sv
design/hba_bin_update.sv
design/histogram_bin_accumulator_unit.sv
tb/sv/histogram_bin_accumulator_unit_tb.sv
